>>> rtl/stpc_pkg.sv
// Package for the stepper position controller: word types, config register
// layout, register indexes and reset values. No dependencies.
package stpc_pkg;

  typedef struct packed {
    logic        opcode;
    logic [15:0] target_position;
    logic        left_switch_n;
    logic        right_switch_n;
  } stpc_in_t;

  typedef struct packed {
    logic [3:0]  coils;
    logic [15:0] current_position;
    logic        is_calibrated;
    logic        at_target;
    logic        command_accepted;
    logic        stepped;
  } stpc_out_t;

  typedef struct packed {
    logic [7:0]  step_delay;
    logic        full_step;
    logic [31:0] coil_patterns;
  } stpc_cfg_t;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_DELAY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_STEP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COIL_PATTERNS = 2'd2;

  localparam logic [7:0]  STEP_DELAY_RST    = 8'd10;
  localparam logic        FULL_STEP_RST     = 1'b0;
  localparam logic [31:0] COIL_PATTERNS_RST = 32'd2628007192;

  localparam logic OPC_TICK    = 1'b0;
  localparam logic OPC_SET_POS = 1'b1;

endpackage

>>> rtl/stepper_position_controller_core.sv
// Top level of the stepper position controller: input word register, update
// engine, result register and configuration port.
// Depends on stpc_pkg, stpc_cfg_regs and stpc_engine.
//
// Usage:
//   in_*  : one word per 1 ms tick (opcode 0) or set-position command
//           (opcode 1), with the current levels of both limit switches.
//   out_* : exactly one result word per input word, in order.
//   cfg_* : register writes (0 step_delay, 1 full_step, 2 coil_patterns);
//           always ready, writes past the list are dropped. Write only while
//           no word is in flight.
// Path: an accepted word waits in the input register, then its result is
//   captured in the result register. Throughput: one word per cycle while
//   out_ready is high; the per-word update is a few compares and adds
//   between the input register and the state/result registers.
// Reset: state, divider and flags clear; calibration restarts by moving left
//   to find the left switch. Config returns to delay 10, half stepping and
//   the default coil table.
// Stall: while out_ready is low the result word holds; the input register
//   still takes one more word, then in_ready drops until the result moves.
module stepper_position_controller_core #(
  parameter int unsigned POSITION_BITS = 16,
  parameter int unsigned PATTERN_COUNT = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  stpc_pkg::stpc_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output stpc_pkg::stpc_out_t            out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [stpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data
);
  import stpc_pkg::*;

  stpc_in_t  in_word_r;
  logic      in_vld_r;
  stpc_out_t out_word_r;
  logic      out_vld_r;
  stpc_cfg_t cfg;
  stpc_out_t result;
  logic      calibrated;
  logic      advance;

  // Move the held word into the result register when that slot is free.
  assign advance   = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || advance;
  assign cfg_ready = 1'b1;

  stpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  stpc_engine #(
    .POSITION_BITS (POSITION_BITS),
    .PATTERN_COUNT (PATTERN_COUNT)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_fire  (advance),
    .item       (in_word_r),
    .cfg        (cfg),
    .result     (result),
    .calibrated (calibrated)
  );

  // Input word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r <= in_data;
    end
  end

  // Result word register: hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_word_r <= result;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_word_r;

  // A word cannot both step and be an accepted command.
  a_step_xor_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_word_r.stepped && out_word_r.command_accepted))
    else $error("result word both stepped and accepted a command");

  // A held word with a free result slot always produces a result.
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !out_vld_r) |=> out_vld_r)
    else $error("held input word did not advance");

  // Calibration, once reached, is never lost outside reset.
  a_cal_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(calibrated))
    else $error("calibrated flag dropped");

  // A stepped result on a free slot reflects a tick word.
  a_step_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && result.stepped) |-> (in_word_r.opcode == OPC_TICK))
    else $error("step event on a set-position word");

endmodule

>>> rtl/stpc_cfg_regs.sv
// Configuration registers of the stepper position controller.
// Depends on stpc_pkg.
module stpc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [stpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  output stpc_pkg::stpc_cfg_t            cfg
);
  import stpc_pkg::*;

  logic [7:0]  step_delay_r;
  logic        full_step_r;
  logic [31:0] coil_patterns_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_delay_r    <= STEP_DELAY_RST;
      full_step_r     <= FULL_STEP_RST;
      coil_patterns_r <= COIL_PATTERNS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_STEP_DELAY:    step_delay_r    <= cfg_data[7:0];
        CFG_FULL_STEP:     full_step_r     <= cfg_data[0];
        CFG_COIL_PATTERNS: coil_patterns_r <= cfg_data;
        default: ; // drop writes past the register list
      endcase
    end
  end

  assign cfg.step_delay    = step_delay_r;
  assign cfg.full_step     = full_step_r;
  assign cfg.coil_patterns = coil_patterns_r;

endmodule

>>> rtl/stpc_engine.sv
// Controller state and the per-word update: switch polling, setpoint check,
// tick divider and step event. Depends on stpc_pkg.
module stpc_engine #(
  parameter int unsigned POSITION_BITS = 16,
  parameter int unsigned PATTERN_COUNT = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_fire,
  input  stpc_pkg::stpc_in_t   item,
  input  stpc_pkg::stpc_cfg_t  cfg,
  output stpc_pkg::stpc_out_t  result,
  output logic                 calibrated
);
  import stpc_pkg::*;

  localparam int unsigned W  = POSITION_BITS;
  localparam int unsigned CW = (W > 16) ? W : 16;
  localparam logic [2:0]  IDX_MASK = 3'(PATTERN_COUNT - 1);

  logic [W-1:0] pos_r, pos_nxt;
  logic [W-1:0] tgt_r, tgt_nxt;
  logic [W-1:0] lim_r, lim_nxt;
  logic [2:0]   idx_r, idx_nxt;
  logic         mr_r, mr_nxt;
  logic         cal_r, cal_nxt;
  logic         lf_r, lf_nxt;
  logic [7:0]   tc_r, tc_nxt;
  logic [3:0]   coil_r, coil_nxt;
  logic         accepted;
  logic         stepped;

  // {accept, new direction}
  function automatic logic [1:0] setpoint_chk(input logic [CW-1:0] lim,
                                              input logic [CW-1:0] pos,
                                              input logic [CW-1:0] req,
                                              input logic          mr);
    logic acc;
    logic flip;
    acc  = (lim != '0) && (req <= lim);
    flip = acc && (((req > pos) && !mr) || ((req < pos) && mr));
    return {acc, mr ^ flip};
  endfunction

  always_comb begin
    logic [1:0]    chk;
    logic [CW-1:0] req;
    logic [7:0]    delay;
    logic [7:0]    tc_inc;
    logic [W-1:0]  size;

    pos_nxt  = pos_r;
    tgt_nxt  = tgt_r;
    lim_nxt  = lim_r;
    idx_nxt  = idx_r;
    mr_nxt   = mr_r;
    cal_nxt  = cal_r;
    lf_nxt   = lf_r;
    tc_nxt   = tc_r;
    coil_nxt = coil_r;
    accepted = 1'b0;
    stepped  = 1'b0;
    chk      = '0;
    req      = '0;
    delay    = 8'd1;
    tc_inc   = '0;
    size     = '0;

    // Poll limit switches until calibrated.
    if (!cal_r) begin
      if (!item.left_switch_n && !lf_r) begin
        pos_nxt = '0;
        lf_nxt  = 1'b1;
        mr_nxt  = ~mr_r;
      end else if (!item.right_switch_n) begin
        lim_nxt = pos_r;
        cal_nxt = 1'b1;
        req     = CW'(pos_r >> 1);
        chk     = setpoint_chk(CW'(pos_r), CW'(pos_r), req, ~mr_r);
        mr_nxt  = chk[0];
        if (chk[1]) begin
          tgt_nxt = W'(req);
        end
      end
    end

    if (item.opcode == OPC_SET_POS) begin
      req      = CW'(item.target_position);
      chk      = setpoint_chk(CW'(lim_nxt), CW'(pos_nxt), req, mr_nxt);
      accepted = chk[1];
      mr_nxt   = chk[0];
      if (chk[1]) begin
        tgt_nxt = W'(req);
      end
    end else begin
      delay  = (cfg.step_delay == 8'd0) ? 8'd1 : cfg.step_delay;
      tc_inc = tc_r + 8'd1;
      tc_nxt = tc_inc;
      if (tc_inc >= delay) begin
        tc_nxt   = 8'd0;
        stepped  = 1'b1;
        size     = W'(cfg.full_step ? 2'd2 : 2'd1);
        coil_nxt = cfg.coil_patterns[{idx_nxt, 2'b00} +: 4];
        if ((pos_nxt != tgt_nxt) || !cal_nxt) begin
          if (mr_nxt) begin
            idx_nxt = (idx_nxt + size[2:0]) & IDX_MASK;
            pos_nxt = pos_nxt + size;
          end else begin
            idx_nxt = (idx_nxt - size[2:0]) & IDX_MASK;
            pos_nxt = pos_nxt - size;
          end
        end else if (idx_nxt[0]) begin
          coil_nxt = 4'd0; // idle between full steps: release the coils
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      tgt_r  <= '0;
      lim_r  <= '0;
      idx_r  <= '0;
      mr_r   <= 1'b0;
      cal_r  <= 1'b0;
      lf_r   <= 1'b0;
      tc_r   <= '0;
      coil_r <= '0;
    end else if (item_fire) begin
      pos_r  <= pos_nxt;
      tgt_r  <= tgt_nxt;
      lim_r  <= lim_nxt;
      idx_r  <= idx_nxt;
      mr_r   <= mr_nxt;
      cal_r  <= cal_nxt;
      lf_r   <= lf_nxt;
      tc_r   <= tc_nxt;
      coil_r <= coil_nxt;
    end
  end

  assign result.coils            = coil_nxt;
  assign result.current_position = 16'(pos_nxt);
  assign result.is_calibrated    = cal_nxt;
  assign result.at_target        = (pos_nxt == tgt_nxt);
  assign result.command_accepted = accepted;
  assign result.stepped          = stepped;
  assign calibrated              = cal_r;

endmodule
